// ===== hdl/elevator_target_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// elevator_target_scheduler_defines.svh
// Assertion macros for the scheduler modules, used by ets_ctrl. They expect clk and
// arst_n in scope and vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ELEVATOR_TARGET_SCHEDULER_DEFINES_SVH
`define ELEVATOR_TARGET_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define ETS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ets assertion failed");

// expression must never be true outside reset
`define ETS_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ets forbidden condition seen");

`else

`define ETS_ASSERT(lbl, prop)
`define ETS_NEVER(lbl, expr)

`endif

`endif

// ===== hdl/ets_pkg.sv =====
// ---------------------------------------------------------------------------
// ets_pkg
// Types and codes shared by the elevator target scheduler modules.
// ---------------------------------------------------------------------------
package ets_pkg;

	localparam int FLOOR_W = 5;
	localparam int CMD_W   = 2;
	localparam int HEAD_W  = 2;

	// event codes
	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PASS    = 2'd2;

	// travel heading codes
	localparam logic [HEAD_W-1:0] DIR_STAY = 2'd0;
	localparam logic [HEAD_W-1:0] DIR_UP   = 2'd1;
	localparam logic [HEAD_W-1:0] DIR_DOWN = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [FLOOR_W-1:0] floor_number;
	} item_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] next_stop;
		logic [HEAD_W-1:0]  heading;
	} stop_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture input beat
		logic req_upd;    // request: set pending, widen goal
		logic arr_upd;    // arrival: move cabin, clear pending, stop watching
		logic pass_upd;   // pass step on the latched floor
		logic far_init;   // start farthest-floor scan
		logic near_init;  // start nearest-floor scan
		logic scan_step;  // test one floor, advance pointer
		logic far_load;   // goal takes farthest-scan result
		logic emit;       // load stop register, apply pass step
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd_code;
		logic             floor_ok;
		logic             watching;
		logic             arr_goal;   // latched floor equals goal
		logic             scan_last;  // current scan cycle is the final one
		logic             hit;        // last scan found a pending floor
	} ctl_stat_t;

endpackage

// ===== hdl/ets_datapath.sv =====
// ---------------------------------------------------------------------------
// ets_datapath
// Scheduler state, the one-floor-per-cycle scan unit and the stop register.
// ---------------------------------------------------------------------------
module ets_datapath import ets_pkg::*; #(
	parameter int FLOORS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item,
	input  ctl_cmd_t  cmd,
	output ctl_stat_t stat,
	output stop_t     stop
);

	localparam int PW     = $clog2(FLOORS + 1);
	localparam int WW     = (PW > FLOOR_W) ? PW : FLOOR_W;
	localparam int PIDX_W = $clog2(FLOORS);

	logic [WW-1:0]     cabin_q, goal_q, flr_q, ptr_q, found_q;
	logic [FLOORS-1:0] pending_q;
	logic              watching_q, up_q, hit_q;
	logic [HEAD_W-1:0] dir_q, heading_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [FLOOR_W-1:0] stop_floor_q;

	logic [WW-1:0]     goal_base, goal_new, emit_floor;
	logic [HEAD_W-1:0] emit_dir;
	logic              ptr_ok, hit_now, end_now;

	// goal widening for a request
	always_comb begin
		goal_base = (goal_q == '0) ? flr_q : goal_q;
		if ((dir_q == DIR_UP && flr_q > goal_base) ||
		    (dir_q == DIR_DOWN && flr_q < goal_base)) begin
			goal_new = flr_q;
		end else begin
			goal_new = goal_base;
		end
	end

	assign ptr_ok  = (ptr_q != '0) && (ptr_q <= WW'(FLOORS));
	assign hit_now = ptr_ok && pending_q[PIDX_W'(ptr_q - WW'(1))];
	assign end_now = up_q ? (ptr_q == WW'(FLOORS)) : (ptr_q == WW'(1));

	assign emit_floor = hit_q ? found_q : flr_q;
	assign emit_dir   = (cabin_q > goal_q) ? DIR_DOWN : DIR_UP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cabin_q    <= WW'(1);
			goal_q     <= '0;
			pending_q  <= '0;
			watching_q <= 1'b0;
			dir_q      <= DIR_STAY;
		end else begin
			if (cmd.req_upd) begin
				pending_q[PIDX_W'(flr_q - WW'(1))] <= 1'b1;
				goal_q <= goal_new;
			end
			if (cmd.arr_upd) begin
				cabin_q    <= flr_q;
				pending_q[PIDX_W'(flr_q - WW'(1))] <= 1'b0;
				watching_q <= 1'b0;
			end
			if (cmd.pass_upd) begin
				if (watching_q) begin
					cabin_q <= flr_q;
				end
				watching_q <= 1'b1;
			end
			if (cmd.far_load) begin
				goal_q <= hit_q ? found_q : '0;
			end
			if (cmd.emit) begin
				dir_q <= emit_dir;
				if (watching_q) begin
					cabin_q <= emit_floor;
				end
				watching_q <= 1'b1;
			end
		end
	end

	// payload, scan and stop registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= item.cmd;
			flr_q <= WW'(item.floor_number);
		end
		if (cmd.far_init) begin
			ptr_q <= (dir_q == DIR_UP) ? WW'(FLOORS) : WW'(1);
			up_q  <= (dir_q != DIR_UP);
			hit_q <= 1'b0;
		end
		if (cmd.near_init) begin
			ptr_q <= cabin_q;
			up_q  <= (goal_q > cabin_q);
			hit_q <= 1'b0;
		end
		if (cmd.scan_step) begin
			if (hit_now) begin
				found_q <= ptr_q;
				hit_q   <= 1'b1;
			end else if (!end_now) begin
				ptr_q <= up_q ? (ptr_q + WW'(1)) : (ptr_q - WW'(1));
			end
		end
		if (cmd.emit) begin
			stop_floor_q <= emit_floor[FLOOR_W-1:0];
			heading_q    <= emit_dir;
		end
	end

	assign stat.cmd_code  = cmd_q;
	assign stat.floor_ok  = (flr_q != '0) && (flr_q <= WW'(FLOORS));
	assign stat.watching  = watching_q;
	assign stat.arr_goal  = (flr_q == goal_q);
	assign stat.scan_last = hit_now || end_now;
	assign stat.hit       = hit_q;

	assign stop.next_stop = stop_floor_q;
	assign stop.heading   = heading_q;

endmodule

// ===== hdl/ets_ctrl.sv =====
// ---------------------------------------------------------------------------
// ets_ctrl
// Sequencer for the scheduler: decodes each event and runs the scans.
// ---------------------------------------------------------------------------
`include "elevator_target_scheduler_defines.svh"

module ets_ctrl import ets_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output logic      stop_valid,
	input  logic      stop_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_REQ,
		ST_ARR,
		ST_PASS,
		ST_FAR_INIT,
		ST_FAR_SCAN,
		ST_FAR_LOAD,
		ST_NEAR_INIT,
		ST_NEAR_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || stop_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = item_valid;
				if (item_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (stat.floor_ok) begin
					case (stat.cmd_code)
						CMD_REQUEST: state_d = ST_REQ;
						CMD_ARRIVE:  state_d = stat.watching ? ST_ARR : ST_IDLE;
						CMD_PASS:    state_d = ST_PASS;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_REQ: begin
				cmd.req_upd = 1'b1;
				state_d     = ST_NEAR_INIT;
			end
			ST_ARR: begin
				cmd.arr_upd = 1'b1;
				state_d     = stat.arr_goal ? ST_FAR_INIT : ST_NEAR_INIT;
			end
			ST_PASS: begin
				cmd.pass_upd = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_FAR_INIT: begin
				cmd.far_init = 1'b1;
				state_d      = ST_FAR_SCAN;
			end
			ST_FAR_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_FAR_LOAD;
				end
			end
			ST_FAR_LOAD: begin
				cmd.far_load = 1'b1;
				state_d      = ST_NEAR_INIT;
			end
			ST_NEAR_INIT: begin
				cmd.near_init = 1'b1;
				state_d       = ST_NEAR_SCAN;
			end
			ST_NEAR_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// arrival with nothing pending sends no stop
				if (!stat.hit && stat.cmd_code != CMD_REQUEST) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (stop_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready = (state_q == ST_IDLE);
	assign stop_valid = out_valid_q;

	// a stop is loaded only into a free output register
	`ETS_ASSERT(a_emit_free, cmd.emit |-> out_free)
	// an accepted beat always goes to decode next
	`ETS_ASSERT(a_accept_decode, (item_valid && item_ready) |=> (state_q == ST_DECODE))
	// state updates are issued one at a time
	`ETS_ASSERT(a_cmd_onehot, $onehot0({cmd.req_upd, cmd.arr_upd, cmd.pass_upd,
		cmd.far_load, cmd.emit, cmd.scan_step, cmd.far_init, cmd.near_init}))

endmodule

// ===== hdl/elevator_target_scheduler.sv =====
// ---------------------------------------------------------------------------
// elevator_target_scheduler: SCAN-style stop picker for one elevator cabin
// Requests always yield a stop, arrivals only when the scan finds a pending floor; pass gives none.
// A new event beat is accepted only once the previous event is done, which
// is delayed further while a stop waits in emit for the output register to
// free; the scan behind each event tests one floor per cycle.
// Reset (arst_n low, async): cabin 1, no goal, nothing pending, waiting, stay.
// ---------------------------------------------------------------------------
module elevator_target_scheduler import ets_pkg::*; #(
	parameter int FLOORS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	// event channel
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	// stop channel
	output logic  stop_valid,
	input  logic  stop_ready,
	output stop_t stop
);

	// Controller walks each request or arrival through decode, the optional
	// farthest-floor scan (arrival at the goal), the nearest-floor scan and
	// the emit step. The datapath owns all scheduler state and a single scan
	// pointer that tests one pending bit per cycle.
	//
	// The stop register is separate from the event side: a finished stop may
	// sit unclaimed while the next event beat is accepted and worked on; only
	// a second stop waits in the emit step for the register to free up.
	//
	// Events naming floor 0, a floor above FLOORS, or the unused command
	// code are accepted and dropped without touching state.

	ctl_cmd_t  ctl_cmd;
	ctl_stat_t ctl_stat;

	ets_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stop_valid (stop_valid),
		.stop_ready (stop_ready),
		.stat       (ctl_stat),
		.cmd        (ctl_cmd)
	);

	ets_datapath #(
		.FLOORS (FLOORS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (ctl_cmd),
		.stat   (ctl_stat),
		.stop   (stop)
	);

endmodule
